FILE: rtl/apm_pkg.sv
package apm_pkg;

  localparam int SYM_W = 4;
  localparam int LEN_W = 5;
  localparam int STATE_W = 5;
  localparam int PAT_W = 64;
  localparam int PAT_SLOTS = 16;
  localparam int OFFSET_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_SYMBOLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

  typedef enum logic {
    ST_RUN,
    ST_REPLAY
  } state_t;

  typedef struct packed {
    logic             load;
    logic             step;
    logic             restart;
    logic             sym_ok;
    logic [SYM_W-1:0] sym;
  } chain_ctl_t;

endpackage

FILE: rtl/automaton_pattern_matcher_core.sv
// Finite-automaton string matcher built as a row of MAX_PATTERN cells, one per
// pattern prefix. Each cell holds one bit telling whether its prefix ends at the
// current text symbol and takes its neighbor's bit on each step, so one text
// symbol is accepted per clock outside a rebuild and its result is held in the
// output register; input stalls while a result waits unread and is taken again
// in the cycle that result is read. A write to
// pattern_symbols or pattern_length rebuilds the automaton state for the new
// pattern by replaying the first q pattern symbols through the same row, where
// q is the current state (zero when it exceeds the new length); in_ready is low
// while the replay runs after each write. Matching reports the first completion of
// the pattern in a text with its start offset, and not_found on the last symbol
// when none occurred; first restarts a text at offset zero.
module automaton_pattern_matcher_core #(
  parameter int MAX_PATTERN = 16,
  parameter int ALPHABET = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [apm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [apm_pkg::PAT_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [apm_pkg::SYM_W-1:0]     symbol,
  input  logic                          first,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          match,
  output logic [apm_pkg::OFFSET_W-1:0]  offset,
  output logic                          not_found
);
  import apm_pkg::*;

  localparam int CAP = (MAX_PATTERN < PAT_SLOTS) ? MAX_PATTERN : PAT_SLOTS;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam int HIT_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [PAT_W-1:0]         pat_syms;
  logic [LEN_W-1:0]         pat_len;
  logic [LEN_W-1:0]         len_eff;
  state_t                   st;
  state_t                   st_next;
  logic [STATE_W-1:0]       q_raw;
  logic [STATE_W-1:0]       target;
  logic [LEN_W-1:0]         idx;
  logic [LEN_W-1:0]         idx_next;
  logic [POSITION_BITS-1:0] pos;
  logic                     found;
  chain_ctl_t               ctl;
  logic [MAX_PATTERN-1:0]   hit_next;
  logic [STATE_W-1:0]       state_next;
  logic                     cfg_hit;
  logic                     accept;
  logic [HIT_IDX_W-1:0]     m_idx;
  logic                     hit_m;
  logic                     found_base;
  logic [POSITION_BITS-1:0] pos_base;
  logic [POSITION_BITS-1:0] pos_next;
  logic [POSITION_BITS-1:0] start;
  logic [32:0]              start_ext;

  assign cfg_hit = cfg_write &&
                   (cfg_index == REG_PATTERN_SYMBOLS || cfg_index == REG_PATTERN_LENGTH);

  always_comb begin
    if (pat_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(pat_len) > CAP) begin
      len_eff = LEN_W'(CAP);
    end else begin
      len_eff = pat_len;
    end
  end

  assign target = (q_raw > STATE_W'(len_eff)) ? '0 : q_raw;
  assign in_ready = (st == ST_RUN) && (!out_valid || out_ready);
  assign accept = in_valid && in_ready;

  always_comb begin
    st_next = st;
    idx_next = idx;
    ctl = '0;
    case (st)
      ST_RUN: begin
        ctl.step = accept;
        ctl.restart = first;
        ctl.sym_ok = (32'(symbol) < ALPHABET);
        ctl.sym = symbol;
      end
      ST_REPLAY: begin
        if (STATE_W'(idx) == target) begin
          st_next = ST_RUN;
        end else begin
          ctl.step = 1'b1;
          ctl.sym_ok = 1'b1;
          ctl.sym = pat_syms[SYM_W*idx[3:0] +: SYM_W];
          idx_next = idx + LEN_W'(1);
        end
      end
      default: begin
        st_next = ST_RUN;
      end
    endcase
    if (cfg_hit) begin
      ctl = '0;
      ctl.load = 1'b1;
      st_next = ST_REPLAY;
      idx_next = '0;
    end
  end

  apm_chain #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .pat_syms   (pat_syms),
    .len_eff    (len_eff),
    .hit_next   (hit_next),
    .state_next (state_next)
  );

  assign m_idx = HIT_IDX_W'(len_eff - LEN_W'(1));
  assign hit_m = hit_next[m_idx];
  assign found_base = first ? 1'b0 : found;
  assign pos_base = first ? '0 : pos;
  assign pos_next = (pos_base == POS_MAX) ? pos_base : pos_base + POSITION_BITS'(1);
  assign start = (pos_next >= POSITION_BITS'(len_eff)) ?
                 pos_next - POSITION_BITS'(len_eff) : '0;
  assign start_ext = 33'(start);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RUN;
      idx <= '0;
      pat_syms <= '0;
      pat_len <= LEN_W'(1);
      q_raw <= '0;
      pos <= '0;
      found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      idx <= idx_next;
      if (cfg_write && cfg_index == REG_PATTERN_SYMBOLS) begin
        pat_syms <= cfg_data;
      end
      if (cfg_write && cfg_index == REG_PATTERN_LENGTH) begin
        pat_len <= cfg_data[LEN_W-1:0];
      end
      if (accept) begin
        q_raw <= state_next;
        pos <= pos_next;
        found <= found_base | hit_m;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      match <= hit_m & ~found_base;
      offset <= (hit_m & ~found_base) ?
                ((start_ext > 33'hFFFF) ? 16'hFFFF : start_ext[15:0]) : '0;
      not_found <= last & ~(found_base | hit_m);
    end
  end

  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> !in_ready)
    else $error("input taken during rebuild");

  a_replay_bound: assert property (@(posedge clk) disable iff (rst)
    (st == ST_REPLAY) |-> (STATE_W'(idx) <= target))
    else $error("replay ran past its target");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(match && not_found))
    else $error("match and not_found together");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !match) |-> (offset == '0))
    else $error("offset set without match");

  a_state_cap: assert property (@(posedge clk) disable iff (rst)
    (st == ST_RUN && $past(accept)) |-> (q_raw <= STATE_W'(len_eff)))
    else $error("state beyond pattern length");

endmodule

FILE: rtl/apm_cell.sv
module apm_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  apm_pkg::chain_ctl_t       ctl,
  input  logic                      prev,
  input  logic [apm_pkg::SYM_W-1:0] psym,
  input  logic                      en,
  output logic                      hit,
  output logic                      hit_next
);
  import apm_pkg::*;

  always_comb begin
    if (ctl.load) begin
      hit_next = 1'b0;
    end else if (ctl.step) begin
      hit_next = en & prev & ctl.sym_ok & (ctl.sym == psym);
    end else begin
      hit_next = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= hit_next;
    end
  end

endmodule

FILE: rtl/apm_chain.sv
module apm_chain #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  apm_pkg::chain_ctl_t         ctl,
  input  logic [apm_pkg::PAT_W-1:0]   pat_syms,
  input  logic [apm_pkg::LEN_W-1:0]   len_eff,
  output logic [MAX_PATTERN-1:0]      hit_next,
  output logic [apm_pkg::STATE_W-1:0] state_next
);
  import apm_pkg::*;

  logic [MAX_PATTERN-1:0] hit;
  logic [MAX_PATTERN-1:0] prev;

  // cell i tracks whether the prefix of length i+1 ends at the current symbol
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [SYM_W-1:0] psym;
    logic             en;

    if (i == 0) begin : g_head
      assign prev[i] = 1'b1;
    end else begin : g_link
      assign prev[i] = hit[i-1] & ~ctl.restart;
    end

    if (i < PAT_SLOTS) begin : g_sym
      assign psym = pat_syms[SYM_W*i +: SYM_W];
    end else begin : g_nosym
      assign psym = '0;
    end

    assign en = (i < int'(len_eff));

    apm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .prev     (prev[i]),
      .psym     (psym),
      .en       (en),
      .hit      (hit[i]),
      .hit_next (hit_next[i])
    );
  end

  // longest live prefix is the automaton state
  always_comb begin
    state_next = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (hit_next[i]) begin
        state_next = STATE_W'(i + 1);
      end
    end
  end

endmodule
